FILE: hw/rtl/tdpt_pkg.sv
package tdpt_pkg;

  // Default candidate width
  localparam int NUM_BITS_DEF = 31;

  // First odd trial divisor and its square
  localparam int FIRST_DIVISOR = 3;
  localparam int FIRST_SQUARE  = 9;

  // Handshake between the sequencer and the remainder unit
  typedef struct packed {
    logic done;      // remainder ready, one-cycle pulse
    logic rem_zero;  // remainder is zero, valid with done
  } tdpt_rem_status_t;

endpackage

FILE: hw/rtl/tdpt_rem_unit.sv
module tdpt_rem_unit
  import tdpt_pkg::*;
#(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [NUM_BITS-1:0] divisor,
  output tdpt_rem_status_t    status
);

  localparam int CNT_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);

  logic                active;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [NUM_BITS-1:0] dvd;
  logic [NUM_BITS-1:0] rem;

  logic [NUM_BITS:0]   rem_sh;
  logic [NUM_BITS:0]   diff;
  logic [NUM_BITS-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, dvd[NUM_BITS-1]};
    diff   = rem_sh - {1'b0, divisor};
    if (diff[NUM_BITS]) begin
      rem_next = rem_sh[NUM_BITS-1:0];
    end else begin
      rem_next = diff[NUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= CNT_LAST;
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      rem <= '0;
    end else if (active) begin
      dvd <= {dvd[NUM_BITS-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

  a_done_after_active: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active))
    else $error("remainder done without an active division");

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> !active)
    else $error("division launched while one is running");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < divisor))
    else $error("final remainder not below divisor");

endmodule

FILE: hw/rtl/trial_division_prime_test_top.sv
// Trial-division primality test. Pulse start with a candidate while busy is
// low; exactly one result follows, shown on prime_flag for a single cycle with
// done high, and it must be taken in that cycle: the block cannot be stalled.
// Numbers below 2 and all even numbers, 2 included, are answered in the
// cycle after start, with busy never raised. An odd candidate n of 3 or more
// is divided by each odd divisor from 3 upward while the divisor squared does
// not exceed n; for each divisor the sequencer checks the bound, launches the
// remainder unit, waits while it retires one quotient bit per cycle, and takes
// its done pulse. A prime therefore runs through every odd divisor up to its
// square root. busy stays high for the whole test; start is ignored while busy
// is high.
module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [NUM_BITS-1:0] candidate,
  output logic                done,
  output logic                prime_flag
);

  localparam int SQ_W = NUM_BITS + 2;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_LAUNCH = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [NUM_BITS-1:0] n;        // candidate under test
  logic [NUM_BITS-1:0] d;        // current odd trial divisor
  logic [SQ_W-1:0]     sq;       // d * d, kept by increments
  logic                rem_go;
  tdpt_rem_status_t    rem_status;

  logic                accept;
  logic                small_or_even;
  logic                is_two;

  assign accept        = start && (state == ST_IDLE);
  assign is_two        = (candidate == NUM_BITS'(2));
  assign small_or_even = (candidate < NUM_BITS'(2)) || !candidate[0];
  assign busy          = (state != ST_IDLE);
  assign rem_go        = (state == ST_LAUNCH);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !small_or_even && !is_two) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Past the square root: no divisor left, so n is prime
        if (sq > {2'b00, n}) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT: begin
        if (rem_status.done) begin
          state_next = rem_status.rem_zero ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          // Answer trivial candidates at once
          if (start && (small_or_even || is_two)) begin
            done <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (sq > {2'b00, n}) begin
            done <= 1'b1;
          end
        end
        ST_WAIT: begin
          if (rem_status.done && rem_status.rem_zero) begin
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: candidate, divisor, square and result flag
  always_ff @(posedge clk) begin
    if (accept) begin
      n          <= candidate;
      d          <= NUM_BITS'(FIRST_DIVISOR);
      sq         <= SQ_W'(FIRST_SQUARE);
      prime_flag <= is_two;
    end else if (state == ST_CHECK) begin
      if (sq > {2'b00, n}) begin
        prime_flag <= 1'b1;
      end
    end else if (state == ST_WAIT && rem_status.done) begin
      if (rem_status.rem_zero) begin
        prime_flag <= 1'b0;
      end else begin
        // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
        d  <= d + NUM_BITS'(2);
        sq <= sq + {d, 2'b00} + SQ_W'(4);
      end
    end
  end

  tdpt_rem_unit #(
    .NUM_BITS (NUM_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (rem_go),
    .dividend (n),
    .divisor  (d),
    .status   (rem_status)
  );

  a_done_frees_block: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    busy |-> d[0])
    else $error("trial divisor is even");

  a_prime_is_odd_or_two: assert property (@(posedge clk) disable iff (rst)
    (done && prime_flag) |-> (n[0] || (n == NUM_BITS'(2))))
    else $error("even candidate other than two reported prime");

  a_launch_from_check: assert property (@(posedge clk) disable iff (rst)
    rem_go |-> $past(state == ST_CHECK))
    else $error("division launched without a bound check");

endmodule

FILE: verif/prime_flag_checker.sv
module prime_flag_checker
  import tdpt_pkg::*;
#(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [NUM_BITS-1:0] candidate,
  input  logic                done,
  input  logic                prime_flag,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [NUM_BITS-1:0] value;
    bit                  flag;
  } verdict_t;

  verdict_t verdicts_due [$];

  // Odd trial divisors up to and including the square root.
  function automatic bit primality(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    verdict_t oldest;
    verdict_t fresh;
    if (rst) begin
      verdicts_due.delete();
      pending <= 0;
    end else begin
      // Retire first: a result always belongs to an earlier beat.
      if (done) begin
        if (verdicts_due.size() == 0) begin
          $error("prime_flag: no candidate waiting, actual %0b", prime_flag);
          fail_count <= fail_count + 1;
        end else begin
          oldest = verdicts_due.pop_front();
          if (prime_flag !== oldest.flag) begin
            $error("prime_flag (candidate %0d): expected %0b, actual %0b",
                   oldest.value, oldest.flag, prime_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        fresh.value = candidate;
        fresh.flag  = primality(64'(candidate));
        verdicts_due.push_back(fresh);
      end
      pending <= verdicts_due.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
module tb_top
  import tdpt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB           = NUM_BITS_DEF;
  localparam int RANDOM_BEATS = 100;
  // The last beats go out back to back, with no idle bursts.
  localparam int CALM_TAIL    = 20;
  // The block has no latency left once the last result is in; allow a margin.
  localparam int DRAIN_CYCLES = 64;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          start     = 1'b0;
  logic [NB-1:0] candidate = '0;
  logic          busy;
  logic          done;
  logic          prime_flag;
  int            fail_count;
  int            pending;

  logic [NB-1:0] corner_values [$];

  always #5 clk = ~clk;

  trial_division_prime_test_top #(
    .NUM_BITS(NB)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .candidate (candidate),
    .done      (done),
    .prime_flag(prime_flag)
  );

  prime_flag_checker #(
    .NUM_BITS(NB)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .candidate (candidate),
    .done      (done),
    .prime_flag(prime_flag),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Present one beat and hold it until the block takes it (start high,
  // busy low at an edge). Then either leave start high for the next beat or
  // drop it for a random idle burst, scrambling the candidate meanwhile.
  task automatic send_beat(input logic [NB-1:0] value, input bit allow_idle);
    int gap;
    start     <= 1'b1;
    candidate <= value;
    do @(posedge clk); while (busy);
    if (allow_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 18);
      start     <= 1'b0;
      candidate <= NB'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // Keep random candidates cheap: the block's cost grows with the smallest
  // factor, so a large odd prime would eat the whole cycle budget.
  //  - small values cover low bits, odd primes and odd composites
  //  - large even values toggle every upper bit and are answered at once
  //  - large odd values are built with a small odd factor
  function automatic logic [NB-1:0] random_candidate();
    int unsigned     pick;
    longint unsigned factor;
    longint unsigned top_mult;
    longint unsigned mult;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      return NB'($urandom_range(0, 65535));
    end else if (pick < 8) begin
      return NB'($urandom()) & ~NB'(1);
    end else begin
      factor   = 2 * $urandom_range(1, 127) + 1;
      top_mult = ((64'd1 << NB) - 1) / factor;
      mult     = 2 * longint'($urandom_range(0, int'((top_mult - 1) / 2))) + 1;
      return NB'(factor * mult);
    end
  endfunction

  initial begin
    int sent;
    // Zero and one are not prime, two is, squares of odd primes sit right
    // on the divisor bound, and the top of the range is a full-width prime.
    corner_values = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd8, 31'd9,
      31'd15, 31'd25, 31'd49, 31'd121, 31'd169, 31'd65521, 31'd65535,
      31'd1073741824, 31'd1073741825, 31'd1162261467,
      31'd2147483645, 31'd2147483646, 31'd2147483647
    };

    // Hold reset, then release it once.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i]) send_beat(corner_values[i], 1'b1);

    for (sent = 0; sent < RANDOM_BEATS; sent++) begin
      send_beat(random_candidate(), sent < RANDOM_BEATS - CALM_TAIL);
    end
    start <= 1'b0;

    // Let the checker log the last beat at a clock edge, then wait
    // for every verdict and a short drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("** trial_division_prime_test_top: PASSED **");
    end else begin
      $display("** trial_division_prime_test_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: one full-width prime alone is the slowest test; the rest
  // stays well under that, so 60 ms is several times the slowest good run.
  initial begin
    #60_000_000;
    $display("** trial_division_prime_test_top: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_rem_unit.sv
hw/rtl/trial_division_prime_test_top.sv
verif/prime_flag_checker.sv
verif/tb_top.sv
